// ===== sv/vffp_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the voxel first-fit placer.
// No dependencies; the controller, datapath, top and testbench import this package.
package vffp_pkg;

  localparam int GRID_DIM_DEF      = 32;
  localparam int OBJECT_DIM_DEF    = 16;
  localparam int MAX_ROTATIONS_DEF = 32;

  typedef enum logic [1:0] {
    OP_CLEAR     = 2'd0,
    OP_LOAD_MASK = 2'd1,
    OP_LOAD_BOX  = 2'd2,
    OP_PLACE     = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    REG_ROT_COUNT = 3'd0,
    REG_OBJ_EXT_X = 3'd1,
    REG_OBJ_EXT_Y = 3'd2,
    REG_OBJ_EXT_Z = 3'd3,
    REG_GRID_EXT_X = 3'd4,
    REG_GRID_EXT_Y = 3'd5,
    REG_GRID_EXT_Z = 3'd6,
    REG_NONE       = 3'd7
  } reg_e;

  typedef struct packed {
    logic [5:0] rotation_count;
    logic [4:0] object_extent_x;
    logic [4:0] object_extent_y;
    logic [4:0] object_extent_z;
    logic [5:0] grid_extent_x;
    logic [5:0] grid_extent_y;
    logic [5:0] grid_extent_z;
  } cfg_t;

  // Controller to datapath.
  typedef struct packed {
    logic ready;
    logic clr_step;
    logic scan_adv;
    logic walk_init;
    logic vox_step;
    logic chk;
    logic mark;
    logic pick;
    logic emit_place;
    logic emit_close;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic req_valid;
    op_e  op;
    logic count_zero;
    logic scan_done;
    logic fit_any;
    logic walk_empty;
    logic cand_next_zero;
    logic vox_last;
    logic clr_last;
    logic out_free;
    logic count_done;
  } sts_t;

endpackage

// ===== sv/vffp_req_if.sv =====
`timescale 1ns / 1ps
// Request channel of the voxel placer: valid/ready plus the request fields.
// Depends on nothing.
interface vffp_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [5:0]  coord_x;
  logic [5:0]  coord_y;
  logic [5:0]  coord_z;
  logic [31:0] voxel_mask;
  logic [4:0]  rotation_slot;
  logic [4:0]  size_x;
  logic [4:0]  size_y;
  logic [4:0]  size_z;
  logic [5:0]  instance_count;

  modport source (output valid, operation, coord_x, coord_y, coord_z, voxel_mask,
                  rotation_slot, size_x, size_y, size_z, instance_count, input ready);
  modport sink (input valid, operation, coord_x, coord_y, coord_z, voxel_mask,
                rotation_slot, size_x, size_y, size_z, instance_count, output ready);
endinterface

// ===== sv/vffp_res_if.sv =====
`timescale 1ns / 1ps
// Result channel of the voxel placer: valid/ready plus the result fields.
// Depends on nothing.
interface vffp_res_if;
  logic       valid;
  logic       ready;
  logic       placed;
  logic [4:0] place_x;
  logic [4:0] place_y;
  logic [4:0] place_z;
  logic [4:0] rotation_used;
  logic       last_result;

  modport source (output valid, placed, place_x, place_y, place_z, rotation_used,
                  last_result, input ready);
  modport sink (input valid, placed, place_x, place_y, place_z, rotation_used,
                last_result, output ready);
endinterface

// ===== sv/vffp_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer of the voxel placer: clear sweep, position scan, voxel walks.
// Depends on vffp_pkg.
module vffp_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  vffp_pkg::sts_t sts_i,
  output vffp_pkg::cmd_t cmd_o
);
  import vffp_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CLR   = 4'd1;
  localparam logic [3:0] S_POS   = 4'd2;
  localparam logic [3:0] S_RD    = 4'd3;
  localparam logic [3:0] S_CHK   = 4'd4;
  localparam logic [3:0] S_PICK  = 4'd5;
  localparam logic [3:0] S_MRD   = 4'd6;
  localparam logic [3:0] S_MCHK  = 4'd7;
  localparam logic [3:0] S_EMIT  = 4'd8;
  localparam logic [3:0] S_ADV   = 4'd9;
  localparam logic [3:0] S_CLOSE = 4'd10;

  logic [3:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.ready = 1'b1;
        if (sts_i.req_valid) begin
          unique case (sts_i.op)
            OP_CLEAR: state_d = S_CLR;
            OP_PLACE: state_d = sts_i.count_zero ? S_CLOSE : S_POS;
            default:  state_d = S_IDLE;
          endcase
        end
      end
      S_CLR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_POS: begin
        if (sts_i.scan_done) begin
          state_d = S_CLOSE;
        end else if (!sts_i.fit_any) begin
          state_d = S_ADV;
        end else begin
          cmd_o.walk_init = 1'b1;
          state_d = sts_i.walk_empty ? S_PICK : S_RD;
        end
      end
      S_RD: state_d = S_CHK;
      S_CHK: begin
        cmd_o.chk = 1'b1;
        if (sts_i.cand_next_zero) begin
          state_d = S_ADV;
        end else if (sts_i.vox_last) begin
          state_d = S_PICK;
        end else begin
          cmd_o.vox_step = 1'b1;
          state_d = S_RD;
        end
      end
      S_PICK: begin
        cmd_o.pick = 1'b1;
        state_d = sts_i.walk_empty ? S_EMIT : S_MRD;
      end
      S_MRD: state_d = S_MCHK;
      S_MCHK: begin
        cmd_o.mark = 1'b1;
        if (sts_i.vox_last) begin
          state_d = S_EMIT;
        end else begin
          cmd_o.vox_step = 1'b1;
          state_d = S_MRD;
        end
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit_place = 1'b1;
          state_d = sts_i.count_done ? S_CLOSE : S_ADV;
        end
      end
      S_ADV: begin
        cmd_o.scan_adv = 1'b1;
        state_d = S_POS;
      end
      S_CLOSE: begin
        if (sts_i.out_free) begin
          cmd_o.emit_close = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Reset starts with a sweep that clears the occupancy store.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
    end else begin
      state_q <= state_d;
    end
  end

  a_clr_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLR && state_d != S_CLR) |-> sts_i.clr_last)
    else $error("clear sweep left early");
  a_close_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit_close |=> state_q == S_IDLE)
    else $error("closing result not followed by idle");
  a_mark_after_pick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MRD && $past(state_q) != S_MCHK) |-> $past(state_q) == S_PICK)
    else $error("marking walk entered without a pick");
endmodule

// ===== sv/vffp_dp.sv =====
`timescale 1ns / 1ps
// Datapath of the voxel placer: stores, scan and walk counters, result register.
// Depends on vffp_pkg and the two channel interfaces.
module vffp_dp #(
  parameter int GRID_DIM      = vffp_pkg::GRID_DIM_DEF,
  parameter int OBJECT_DIM    = vffp_pkg::OBJECT_DIM_DEF,
  parameter int MAX_ROTATIONS = vffp_pkg::MAX_ROTATIONS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  vffp_pkg::cfg_t cfg_i,
  input  vffp_pkg::cmd_t cmd_i,
  output vffp_pkg::sts_t sts_o,
  vffp_req_if.sink       req,
  vffp_res_if.source     res
);
  import vffp_pkg::*;

  localparam int GW  = $clog2(GRID_DIM);
  localparam int CW  = $clog2(GRID_DIM + 1);
  localparam int SW  = (CW + 2 > 7) ? CW + 2 : 7;
  localparam int OW  = $clog2(OBJECT_DIM);
  localparam int OCW = $clog2(OBJECT_DIM + 1);
  localparam int RW  = (MAX_ROTATIONS > 1) ? $clog2(MAX_ROTATIONS) : 1;
  localparam int RCW = $clog2(MAX_ROTATIONS + 1);
  localparam int OCC_ROWS  = 1 << (2 * GW);
  localparam int OBJ_WORDS = 1 << (3 * OW);

  // Stores. Occupancy rows hold one z column of an (x,y) pair.
  logic [GRID_DIM-1:0] occ_mem [OCC_ROWS];
  logic [31:0]         obj_mem [OBJ_WORDS];
  logic [4:0] box_x_q [MAX_ROTATIONS];
  logic [4:0] box_y_q [MAX_ROTATIONS];
  logic [4:0] box_z_q [MAX_ROTATIONS];

  logic accept;
  logic [CW-1:0] gcx, gcy, gcz;
  logic [OCW-1:0] oex, oey, oez;
  logic [RCW-1:0] nrot;
  logic [CW-1:0] mx_q, my_q, mz_q;
  logic [5:0] count_q, placed_q;
  logic [SW-1:0] s_q, r_q, x_q, y, z;
  logic [SW-1:0] xhi, rhi, r_inc, s_inc, r_new, x_new;
  logic [MAX_ROTATIONS-1:0] fit, cand_q, cand_next;
  logic [SW-1:0] room_x, room_y, room_z;
  logic [OCW-1:0] ni, nj, nk, ni_q, nj_q, nk_q;
  logic [OW-1:0] i_q, j_q, k_q;
  logic [2*GW-1:0] clr_q;
  logic [GW-1:0] ax, ay, zk;
  logic [2*GW-1:0] occ_addr;
  logic [3*OW-1:0] obj_addr;
  logic [GRID_DIM-1:0] occ_rd_q;
  logic [31:0] msk_rd_q;
  logic [RW-1:0] rot_q, rot_low;
  logic occ_we;
  logic [2*GW-1:0] occ_wa;
  logic [GRID_DIM-1:0] occ_wd;

  assign req.ready = cmd_i.ready;
  assign accept = req.valid && cmd_i.ready;

  always_comb begin
    gcx  = (cfg_i.grid_extent_x > GRID_DIM) ? CW'(GRID_DIM) : CW'(cfg_i.grid_extent_x);
    gcy  = (cfg_i.grid_extent_y > GRID_DIM) ? CW'(GRID_DIM) : CW'(cfg_i.grid_extent_y);
    gcz  = (cfg_i.grid_extent_z > GRID_DIM) ? CW'(GRID_DIM) : CW'(cfg_i.grid_extent_z);
    oex  = (cfg_i.object_extent_x > OBJECT_DIM) ? OCW'(OBJECT_DIM)
                                                : OCW'(cfg_i.object_extent_x);
    oey  = (cfg_i.object_extent_y > OBJECT_DIM) ? OCW'(OBJECT_DIM)
                                                : OCW'(cfg_i.object_extent_y);
    oez  = (cfg_i.object_extent_z > OBJECT_DIM) ? OCW'(OBJECT_DIM)
                                                : OCW'(cfg_i.object_extent_z);
    nrot = (cfg_i.rotation_count > MAX_ROTATIONS) ? RCW'(MAX_ROTATIONS)
                                                  : RCW'(cfg_i.rotation_count);
  end

  // Diagonal scan: s = x+y+z, r = x+y.
  assign y = r_q - x_q;
  assign z = s_q - r_q;

  always_comb begin
    xhi   = (r_q < SW'(mx_q)) ? r_q : SW'(mx_q);
    rhi   = (s_q < SW'(mx_q) + SW'(my_q)) ? s_q : SW'(mx_q) + SW'(my_q);
    r_inc = r_q + SW'(1);
    s_inc = s_q + SW'(1);
    if (r_inc <= rhi) begin
      r_new = r_inc;
    end else begin
      r_new = (s_inc > SW'(mz_q)) ? s_inc - SW'(mz_q) : '0;
    end
    x_new = (r_new > SW'(my_q)) ? r_new - SW'(my_q) : '0;
  end

  always_comb begin
    fit = '0;
    for (int n = 0; n < MAX_ROTATIONS; n++) begin
      if (RCW'(n) < nrot && x_q + SW'(box_x_q[n]) < SW'(mx_q)
          && y + SW'(box_y_q[n]) < SW'(my_q) && z + SW'(box_z_q[n]) < SW'(mz_q)) begin
        fit[n] = 1'b1;
      end
    end
  end

  // The walk is clipped to the grid extent in use.
  always_comb begin
    room_x = SW'(gcx) - x_q;
    room_y = SW'(gcy) - y;
    room_z = SW'(gcz) - z;
    ni = (SW'(oex) <= room_x) ? oex : OCW'(room_x);
    nj = (SW'(oey) <= room_y) ? oey : OCW'(room_y);
    nk = (SW'(oez) <= room_z) ? oez : OCW'(room_z);
  end

  always_comb begin
    rot_low = '0;
    for (int n = MAX_ROTATIONS - 1; n >= 0; n--) begin
      if (cand_q[n]) rot_low = RW'(n);
    end
  end

  assign ax = GW'(x_q + SW'(i_q));
  assign ay = GW'(y + SW'(j_q));
  assign zk = GW'(z + SW'(k_q));
  assign occ_addr = {ax, ay};
  assign obj_addr = {i_q, j_q, k_q};
  assign cand_next = occ_rd_q[zk] ? (cand_q & ~msk_rd_q[MAX_ROTATIONS-1:0]) : cand_q;

  always_comb begin
    sts_o.req_valid      = req.valid;
    sts_o.op             = op_e'(req.operation);
    sts_o.count_zero     = (req.instance_count == '0);
    sts_o.scan_done      = s_q > SW'(mx_q) + SW'(my_q) + SW'(mz_q);
    sts_o.fit_any        = |fit;
    sts_o.walk_empty     = (ni == '0) || (nj == '0) || (nk == '0);
    sts_o.cand_next_zero = (cand_next == '0);
    sts_o.vox_last       = (OCW'(i_q) + OCW'(1) == ni_q) && (OCW'(j_q) + OCW'(1) == nj_q)
                           && (OCW'(k_q) + OCW'(1) == nk_q);
    sts_o.clr_last       = &clr_q;
    sts_o.out_free       = !res.valid || res.ready;
    sts_o.count_done     = (placed_q + 6'd1 == count_q);
  end

  // Occupancy store: clear sweep or read-modify-write of one marked row.
  always_comb begin
    occ_we = 1'b0;
    occ_wa = occ_addr;
    occ_wd = occ_rd_q | (GRID_DIM'(1) << zk);
    if (cmd_i.clr_step) begin
      occ_we = 1'b1;
      occ_wa = clr_q;
      occ_wd = '0;
    end else if (cmd_i.mark && msk_rd_q[rot_q]) begin
      occ_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (occ_we) occ_mem[occ_wa] <= occ_wd;
    occ_rd_q <= occ_mem[occ_addr];
  end

  always_ff @(posedge clk_i) begin
    if (accept && op_e'(req.operation) == OP_LOAD_MASK && req.coord_x < OBJECT_DIM
        && req.coord_y < OBJECT_DIM && req.coord_z < OBJECT_DIM) begin
      obj_mem[{OW'(req.coord_x), OW'(req.coord_y), OW'(req.coord_z)}] <= req.voxel_mask;
    end
    msk_rd_q <= obj_mem[obj_addr];
  end

  always_ff @(posedge clk_i) begin
    if (accept && op_e'(req.operation) == OP_LOAD_BOX && req.rotation_slot < MAX_ROTATIONS)
    begin
      box_x_q[RW'(req.rotation_slot)] <= req.size_x;
      box_y_q[RW'(req.rotation_slot)] <= req.size_y;
      box_z_q[RW'(req.rotation_slot)] <= req.size_z;
    end
  end

  // Scan and walk registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mx_q <= (req.coord_x < gcx) ? CW'(req.coord_x) : gcx;
      my_q <= (req.coord_y < gcy) ? CW'(req.coord_y) : gcy;
      mz_q <= (req.coord_z < gcz) ? CW'(req.coord_z) : gcz;
      s_q  <= '0;
      r_q  <= '0;
      x_q  <= '0;
    end else if (cmd_i.scan_adv) begin
      if (x_q < xhi) begin
        x_q <= x_q + SW'(1);
      end else begin
        if (r_inc > rhi) s_q <= s_inc;
        r_q <= r_new;
        x_q <= x_new;
      end
    end
    if (cmd_i.walk_init) begin
      cand_q <= fit;
      ni_q   <= ni;
      nj_q   <= nj;
      nk_q   <= nk;
    end else if (cmd_i.chk) begin
      cand_q <= cand_next;
    end
    if (cmd_i.pick) rot_q <= rot_low;
    if (cmd_i.walk_init || cmd_i.pick) begin
      i_q <= '0;
      j_q <= '0;
      k_q <= '0;
    end else if (cmd_i.vox_step) begin
      if (OCW'(k_q) + OCW'(1) < nk_q) begin
        k_q <= k_q + OW'(1);
      end else begin
        k_q <= '0;
        if (OCW'(j_q) + OCW'(1) < nj_q) begin
          j_q <= j_q + OW'(1);
        end else begin
          j_q <= '0;
          i_q <= i_q + OW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= '0;
      count_q   <= '0;
      placed_q  <= '0;
      res.valid <= 1'b0;
    end else begin
      if (accept) begin
        clr_q    <= '0;
        count_q  <= req.instance_count;
        placed_q <= '0;
      end else begin
        if (cmd_i.clr_step) clr_q <= clr_q + (2*GW)'(1);
        if (cmd_i.emit_place) placed_q <= placed_q + 6'd1;
      end
      if (cmd_i.emit_place || cmd_i.emit_close) begin
        res.valid <= 1'b1;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_place || cmd_i.emit_close) begin
      res.placed        <= cmd_i.emit_place;
      res.last_result   <= cmd_i.emit_close;
      res.place_x       <= cmd_i.emit_place ? 5'(x_q) : 5'd0;
      res.place_y       <= cmd_i.emit_place ? 5'(y) : 5'd0;
      res.place_z       <= cmd_i.emit_place ? 5'(z) : 5'd0;
      res.rotation_used <= cmd_i.emit_place ? 5'(rot_q) : 5'd0;
    end
  end

  a_place_in_limits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_place |-> (x_q < SW'(mx_q) && y < SW'(my_q) && z < SW'(mz_q)))
    else $error("placement outside search limits");
  a_place_has_cand: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_place |-> cand_q[rot_q])
    else $error("placed rotation is not a surviving candidate");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    placed_q <= count_q)
    else $error("placed more instances than requested");
endmodule

// ===== sv/voxel_first_fit_placer_top.sv =====
`timescale 1ns / 1ps
// Top level of the voxel first-fit placer: APB register bank and hookup.
// Depends on vffp_pkg, vffp_req_if, vffp_res_if, vffp_ctrl and vffp_dp.
//
// Usage: requests arrive on req_i (valid/ready). Operation 0 clears the
// occupancy grid, 1 loads one object mask word, 2 loads one rotation box
// size, 3 places up to instance_count instances. Results leave on res_o.
// Clear and loads produce no result; a placement gives one result per placed
// instance followed by a closing result with last_result set.
// A clear sweeps all GRID_DIM*GRID_DIM occupancy rows (1024 by default), one
// row of GRID_DIM cells per cycle. A placement steps through a fit check and
// an advance state per scanned position, a read and a check state per object
// voxel checked (the occupancy and mask memories have one registered read
// port each), a pick state for the rotation, a read and a mark state per
// voxel marked, and an emit state per result; the voxel walk dominates.
// After reset the block runs the same clearing sweep before req_i.ready
// rises. A stalled receiver holds the result register and the scan waits.
// Registers are written over APB; the user must write them only while the block is idle (not enforced by the block).
module voxel_first_fit_placer_top #(
  parameter int GRID_DIM      = vffp_pkg::GRID_DIM_DEF,
  parameter int OBJECT_DIM    = vffp_pkg::OBJECT_DIM_DEF,
  parameter int MAX_ROTATIONS = vffp_pkg::MAX_ROTATIONS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  vffp_req_if.sink    req_i,
  vffp_res_if.source  res_o
);
  import vffp_pkg::*;

  cfg_t cfg_q;
  cmd_t cmd;
  sts_t sts;
  reg_e widx;

  assign pready = 1'b1;
  assign widx   = reg_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rotation_count  <= 6'd1;
      cfg_q.object_extent_x <= 5'd1;
      cfg_q.object_extent_y <= 5'd1;
      cfg_q.object_extent_z <= 5'd1;
      cfg_q.grid_extent_x   <= 6'd32;
      cfg_q.grid_extent_y   <= 6'd32;
      cfg_q.grid_extent_z   <= 6'd32;
    end else if (psel && penable && pwrite) begin
      unique case (widx)
        REG_ROT_COUNT:  cfg_q.rotation_count  <= pwdata[5:0];
        REG_OBJ_EXT_X:  cfg_q.object_extent_x <= pwdata[4:0];
        REG_OBJ_EXT_Y:  cfg_q.object_extent_y <= pwdata[4:0];
        REG_OBJ_EXT_Z:  cfg_q.object_extent_z <= pwdata[4:0];
        REG_GRID_EXT_X: cfg_q.grid_extent_x   <= pwdata[5:0];
        REG_GRID_EXT_Y: cfg_q.grid_extent_y   <= pwdata[5:0];
        REG_GRID_EXT_Z: cfg_q.grid_extent_z   <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (widx)
      REG_ROT_COUNT:  prdata = 32'(cfg_q.rotation_count);
      REG_OBJ_EXT_X:  prdata = 32'(cfg_q.object_extent_x);
      REG_OBJ_EXT_Y:  prdata = 32'(cfg_q.object_extent_y);
      REG_OBJ_EXT_Z:  prdata = 32'(cfg_q.object_extent_z);
      REG_GRID_EXT_X: prdata = 32'(cfg_q.grid_extent_x);
      REG_GRID_EXT_Y: prdata = 32'(cfg_q.grid_extent_y);
      REG_GRID_EXT_Z: prdata = 32'(cfg_q.grid_extent_z);
      default:        prdata = '0;
    endcase
  end

  vffp_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  vffp_dp #(
    .GRID_DIM      (GRID_DIM),
    .OBJECT_DIM    (OBJECT_DIM),
    .MAX_ROTATIONS (MAX_ROTATIONS)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .req    (req_i),
    .res    (res_o)
  );
endmodule

// ===== sim/voxel_first_fit_placer_top_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the voxel first-fit placer: a predictor of the grid, masks and
// boxes checks every placement result. It depends on vffp_pkg, both channel interfaces and the top.
module voxel_first_fit_placer_top_tb;
  import vffp_pkg::*;

  typedef struct packed {
    logic [1:0]  operation;
    logic [5:0]  coord_x;
    logic [5:0]  coord_y;
    logic [5:0]  coord_z;
    logic [31:0] voxel_mask;
    logic [4:0]  rotation_slot;
    logic [4:0]  size_x;
    logic [4:0]  size_y;
    logic [4:0]  size_z;
    logic [5:0]  instance_count;
  } place_req_t;

  typedef struct packed {
    logic       placed;
    logic [4:0] px;
    logic [4:0] py;
    logic [4:0] pz;
    logic [4:0] rot;
    logic       last;
  } place_res_t;

  // Holds a private copy of the grid, masks, boxes and registers, and the placements
  // still expected on the result channel.
  class placement_board;
    bit          occ[32768];
    bit [31:0]   masks[4096];
    int          boxes[32][3];
    int          rot_count = 1;
    int          obj_ext[3] = '{1, 1, 1};
    int          grid_ext[3] = '{32, 32, 32};
    place_res_t  pending_places[$];
    int          mismatches = 0;
    int          checked = 0;
    int          placed_seen = 0;

    function int cap(int v, int lim);
      return v > lim ? lim : v;
    endfunction

    function int imin(int a, int b);
      return a < b ? a : b;
    endfunction

    task report(string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      mismatches++;
    endtask

    function void set_reg(reg_e idx, int value);
      case (idx)
        REG_ROT_COUNT:  rot_count = value & 63;
        REG_OBJ_EXT_X:  obj_ext[0] = value & 31;
        REG_OBJ_EXT_Y:  obj_ext[1] = value & 31;
        REG_OBJ_EXT_Z:  obj_ext[2] = value & 31;
        REG_GRID_EXT_X: grid_ext[0] = value & 63;
        REG_GRID_EXT_Y: grid_ext[1] = value & 63;
        REG_GRID_EXT_Z: grid_ext[2] = value & 63;
        default: ;
      endcase
    endfunction

    // Drops rotations that hit occupied cells, or marks the cells of one rotation.
    function bit [31:0] walk(int x, int y, int z, bit [31:0] cand, bit [31:0] mark_bit);
      int hx, hy, hz, c;
      bit [31:0] m;
      hx = imin(x + cap(obj_ext[0], 16), cap(grid_ext[0], 32));
      hy = imin(y + cap(obj_ext[1], 16), cap(grid_ext[1], 32));
      hz = imin(z + cap(obj_ext[2], 16), cap(grid_ext[2], 32));
      for (int i = x; i < hx; i++)
        for (int j = y; j < hy; j++)
          for (int k = z; k < hz; k++) begin
            m = masks[((i - x) * 16 + (j - y)) * 16 + (k - z)];
            c = (i * 32 + j) * 32 + k;
            if (mark_bit != 0) begin
              if ((m & mark_bit) != 0) occ[c] = 1'b1;
            end else if (occ[c]) begin
              cand &= ~m;
              if (cand == 0) return 0;
            end
          end
      return cand;
    endfunction

    function void predict_placement(int cx, int cy, int cz, int count);
      int mx, my, mz, nrot, done, z, y, rot;
      bit [31:0] cand;
      place_res_t res;
      mx = imin(cx, cap(grid_ext[0], 32));
      my = imin(cy, cap(grid_ext[1], 32));
      mz = imin(cz, cap(grid_ext[2], 32));
      nrot = cap(rot_count, 32);
      done = 0;
      // Diagonal order: x+y+z, then x+y, then x, all ascending.
      for (int s = 0; s <= mx + my + mz && done < count; s++)
        for (int r = (s > mz ? s - mz : 0); r <= imin(s, mx + my) && done < count; r++) begin
          z = s - r;
          for (int x = (r > my ? r - my : 0); x <= imin(r, mx) && done < count; x++) begin
            y = r - x;
            cand = 0;
            for (int i = 0; i < nrot; i++)
              if (x + boxes[i][0] < mx && y + boxes[i][1] < my && z + boxes[i][2] < mz)
                cand[i] = 1'b1;
            if (cand != 0) cand = walk(x, y, z, cand, 0);
            if (cand != 0) begin
              rot = 0;
              while (rot < 31 && !cand[rot]) rot++;
              void'(walk(x, y, z, 0, 32'd1 << rot));
              res = '{1'b1, x[4:0], y[4:0], z[4:0], rot[4:0], 1'b0};
              pending_places = {pending_places, res};
              done++;
            end
          end
        end
      res = '{1'b0, 5'd0, 5'd0, 5'd0, 5'd0, 1'b1};
      pending_places = {pending_places, res};
    endfunction

    function void note_request(place_req_t r);
      case (op_e'(r.operation))
        OP_CLEAR: occ = '{default: 1'b0};
        OP_LOAD_MASK:
          if (r.coord_x < 16 && r.coord_y < 16 && r.coord_z < 16)
            masks[(r.coord_x * 16 + r.coord_y) * 16 + r.coord_z] = r.voxel_mask;
        OP_LOAD_BOX: begin
          boxes[r.rotation_slot][0] = r.size_x;
          boxes[r.rotation_slot][1] = r.size_y;
          boxes[r.rotation_slot][2] = r.size_z;
        end
        default: predict_placement(r.coord_x, r.coord_y, r.coord_z, r.instance_count);
      endcase
    endfunction

    task check_result(place_res_t got);
      place_res_t want;
      checked++;
      if (pending_places.size() == 0) begin
        report($sformatf("result %p arrived with nothing expected", got));
        return;
      end
      want = pending_places.pop_front();
      if (got.placed) placed_seen++;
      if (got.placed !== want.placed) report($sformatf("placed %b, want %b", got.placed, want.placed));
      if (got.px !== want.px) report($sformatf("place_x %0d, want %0d", got.px, want.px));
      if (got.py !== want.py) report($sformatf("place_y %0d, want %0d", got.py, want.py));
      if (got.pz !== want.pz) report($sformatf("place_z %0d, want %0d", got.pz, want.pz));
      if (got.rot !== want.rot) report($sformatf("rotation %0d, want %0d", got.rot, want.rot));
      if (got.last !== want.last) report($sformatf("last_result %b, want %b", got.last, want.last));
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel, penable, pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  vffp_req_if req_if ();
  vffp_res_if res_if ();

  voxel_first_fit_placer_top DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .req_i  (req_if),
    .res_o  (res_if)
  );

  placement_board board = new();
  bit  idle_en = 1'b1;
  int  hold_off_cycles = 0;
  int  requests_sent = 0;
  longint cycle_count = 0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 100000000) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Result side: checks accepted results and stalls in bursts or long hold-offs.
  initial begin
    int stall_left;
    stall_left = 0;
    res_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (res_if.valid && res_if.ready)
        board.check_result('{res_if.placed, res_if.place_x, res_if.place_y, res_if.place_z,
                             res_if.rotation_used, res_if.last_result});
      if (hold_off_cycles > 0) begin
        hold_off_cycles--;
        res_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        res_if.ready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 3);
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  function automatic place_req_t noise_req();
    logic [95:0] bits;
    bits = {$urandom, $urandom, $urandom};
    return bits[$bits(place_req_t)-1:0];
  endfunction

  // Called at a rising edge; returns at the edge where the request was accepted.
  task automatic send(place_req_t r);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    req_if.valid          <= 1'b1;
    req_if.operation      <= r.operation;
    req_if.coord_x        <= r.coord_x;
    req_if.coord_y        <= r.coord_y;
    req_if.coord_z        <= r.coord_z;
    req_if.voxel_mask     <= r.voxel_mask;
    req_if.rotation_slot  <= r.rotation_slot;
    req_if.size_x         <= r.size_x;
    req_if.size_y         <= r.size_y;
    req_if.size_z         <= r.size_z;
    req_if.instance_count <= r.instance_count;
    do @(posedge clk_i); while (!req_if.ready);
    board.note_request(r);
    requests_sent++;
  endtask

  task automatic send_mask(int x, int y, int z, bit [31:0] m);
    place_req_t r;
    r = noise_req();
    r.operation = OP_LOAD_MASK;
    r.coord_x = 6'(x); r.coord_y = 6'(y); r.coord_z = 6'(z); r.voxel_mask = m;
    send(r);
  endtask

  task automatic send_box(int slot, int sx, int sy, int sz);
    place_req_t r;
    r = noise_req();
    r.operation = OP_LOAD_BOX;
    r.rotation_slot = 5'(slot); r.size_x = 5'(sx); r.size_y = 5'(sy); r.size_z = 5'(sz);
    send(r);
  endtask

  task automatic send_place(int cx, int cy, int cz, int n);
    place_req_t r;
    r = noise_req();
    r.operation = OP_PLACE;
    r.coord_x = 6'(cx); r.coord_y = 6'(cy); r.coord_z = 6'(cz); r.instance_count = 6'(n);
    send(r);
  endtask

  task automatic send_clear();
    place_req_t r;
    r = noise_req();
    r.operation = OP_CLEAR;
    send(r);
  endtask

  // A clear leaves no result behind, so its sweep is waited out as well.
  task automatic wait_idle();
    req_if.valid <= 1'b0;
    while (board.pending_places.size() != 0) @(posedge clk_i);
    repeat (1100) @(posedge clk_i);
  endtask

  task automatic reg_write(reg_e idx, int value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 5'(4 * idx);
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    board.set_reg(idx, value);
  endtask

  // Every voxel inside the capped object extent is loaded, and every box in use.
  task automatic load_object(int nrot, int sz_hi);
    for (int s = 0; s < (nrot > 32 ? 32 : nrot); s++)
      send_box(s, $urandom_range(0, sz_hi), $urandom_range(0, sz_hi), $urandom_range(0, sz_hi));
    for (int i = 0; i < board.cap(board.obj_ext[0], 16); i++)
      for (int j = 0; j < board.cap(board.obj_ext[1], 16); j++)
        for (int k = 0; k < board.cap(board.obj_ext[2], 16); k++)
          send_mask(i, j, k, ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom);
  endtask

  function automatic int rand_limit();
    case ($urandom_range(0, 11))
      0: return 63;
      1: return 32;
      2: return 0;
      default: return $urandom_range(2, 10);
    endcase
  endfunction

  initial begin
    int phase, nrot, ex, ey, ez;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    req_if.valid = 1'b0;
    {req_if.operation, req_if.coord_x, req_if.coord_y, req_if.coord_z, req_if.voxel_mask,
     req_if.rotation_slot, req_if.size_x, req_if.size_y, req_if.size_z,
     req_if.instance_count} = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    // The block sweeps the grid clear after reset.
    repeat (1100) @(posedge clk_i);

    // Directed part with the reset configuration: one rotation, one voxel object.
    send_box(0, 1, 1, 1);
    send_box(31, 31, 31, 31);
    send_mask(0, 0, 0, 32'h0000_0001);
    send_mask(63, 63, 63, 32'hFFFF_FFFF);
    send_mask(16, 0, 15, 32'hFFFF_FFFF);
    send_place(5, 5, 5, 0);
    send_place(0, 0, 0, 63);
    send_place(4, 4, 4, 63);
    send_place(63, 63, 63, 5);
    send_place(32, 3, 3, 63);
    send_clear();
    send_place(3, 3, 32, 2);
    send_box(0, 0, 0, 0);
    send_place(2, 2, 2, 63);

    phase = 0;
    while (requests_sent < 140 || phase < 5) begin
      wait_idle();
      if (requests_sent >= 125) idle_en = 1'b0;
      case (phase)
        0: begin nrot = 6; ex = 8; ey = 1; ez = 1; end
        1: begin nrot = 0; ex = 1; ey = 16; ez = 1; end
        2: begin nrot = 63; ex = 1; ey = 1; ez = 31; end
        default: begin
          nrot = $urandom_range(1, 8);
          ex = $urandom_range(1, 2); ey = $urandom_range(1, 2); ez = $urandom_range(1, 3);
        end
      endcase
      reg_write(REG_ROT_COUNT, nrot);
      reg_write(REG_OBJ_EXT_X, ex);
      reg_write(REG_OBJ_EXT_Y, ey);
      reg_write(REG_OBJ_EXT_Z, ez);
      reg_write(REG_GRID_EXT_X, phase == 0 ? 1 : (phase == 1 ? 63 : $urandom_range(0, 32)));
      reg_write(REG_GRID_EXT_Y, phase == 2 ? 32 : $urandom_range(4, 32));
      reg_write(REG_GRID_EXT_Z, phase == 1 ? 0 : $urandom_range(4, 32));
      load_object(nrot, phase < 3 ? 31 : 3);
      send_clear();
      if (phase == 3) begin
        // Hold the result side off so the block fills up and stops taking requests.
        hold_off_cycles = 400;
        send_place(12, 12, 12, 63);
        send_place(10, 10, 10, 20);
      end
      for (int n = 0; n < 6; n++) begin
        if (phase == 4 && n == 3) begin
          req_if.valid <= 1'b0;
          while (board.pending_places.size() != 0) @(posedge clk_i);
        end
        if ($urandom_range(0, 9) == 0) send_clear();
        send_place(rand_limit(), rand_limit(), rand_limit(),
                   ($urandom_range(0, 4) == 0) ? 63 : $urandom_range(0, 12));
      end
      phase++;
    end

    req_if.valid <= 1'b0;
    while (board.pending_places.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    $display("Covered %0d requests in %0d configurations; %0d results checked, %0d placements.",
             requests_sent, phase + 1, board.checked, board.placed_seen);
    if (board.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", board.mismatches);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
